// ----- rtl/core/crcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC16-Modbus byte update for the
// fixed-frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    // frame layout
    localparam logic [3:0]  POS_START    = 4'd0;
    localparam logic [3:0]  POS_LENGTH   = 4'd1;
    localparam logic [3:0]  POS_PAYLOAD  = 4'd2;
    localparam logic [3:0]  POS_CRC_LOW  = 4'd14;
    localparam logic [3:0]  POS_LAST     = 4'd15;
    localparam int          MAX_VALUES   = 6;

    // crc16-modbus
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // register reset values
    localparam logic [7:0]  START_RESET  = 8'hA5;
    localparam logic [7:0]  LENGTH_RESET = 8'h0C;

    // register indexes
    localparam logic [0:0]  REG_START    = 1'b0;
    localparam logic [0:0]  REG_LENGTH   = 1'b1;

    // frame status codes
    localparam logic [1:0]  STATUS_OK        = 2'd0;
    localparam logic [1:0]  STATUS_BAD_START = 2'd1;
    localparam logic [1:0]  STATUS_BAD_LEN   = 2'd2;
    localparam logic [1:0]  STATUS_BAD_CRC   = 2'd3;

    typedef logic signed [15:0] t_target;

    typedef struct packed {
        logic [1:0] status;
        t_target    target_0;
        t_target    target_1;
        t_target    target_2;
        t_target    target_3;
        t_target    target_4;
        t_target    target_5;
    } t_result;

    // one byte through the reflected crc, bit at a time
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- rtl/core/crcfr_parser.sv -----
// ----------------------------------------------------------------------------
// crcfr_parser
// Frame state for the receiver: position, running crc, header checks and
// payload bytes. Builds the result for the byte that closes a frame.
// ----------------------------------------------------------------------------
module crcfr_parser #(
    parameter int VALUE_COUNT = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_buffer_start,
    input  logic [7:0]        i_start_byte,
    input  logic [7:0]        i_length_byte,
    output logic              o_last,
    output crcfr_pkg::t_result o_result
);
    import crcfr_pkg::*;

    localparam int PayloadBytes = 2 * VALUE_COUNT;

    logic [3:0]  r_pos;
    logic [15:0] r_crc;
    logic        r_start_ok;
    logic        r_length_ok;
    logic [7:0]  r_crc_low;
    logic [7:0]  r_payload [PayloadBytes];

    logic [3:0]  pos;
    logic [15:0] crc_next;
    logic [15:0] rx_crc;
    logic [1:0]  status;
    t_target     targets [MAX_VALUES];

    // effective position, realigned by the start flag
    assign pos      = i_buffer_start ? POS_START : r_pos;
    assign o_last   = (pos == POS_LAST);
    assign crc_next = crc_feed((pos == POS_START) ? CRC_INIT : r_crc, i_rx_byte);
    assign rx_crc   = {i_rx_byte, r_crc_low};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_START;
            r_crc       <= CRC_INIT;
            r_start_ok  <= 1'b0;
            r_length_ok <= 1'b0;
            r_crc_low   <= 8'h00;
        end else if (i_step) begin
            r_pos <= o_last ? POS_START : pos + 4'd1;
            if (pos < POS_CRC_LOW) begin
                r_crc <= crc_next;
            end else if (o_last) begin
                r_crc <= CRC_INIT;
            end
            if (pos == POS_START) begin
                r_start_ok <= (i_rx_byte == i_start_byte);
            end
            if (pos == POS_LENGTH) begin
                r_length_ok <= (i_rx_byte == i_length_byte);
            end
            if (pos == POS_CRC_LOW) begin
                r_crc_low <= i_rx_byte;
            end
        end
    end

    // payload capture, only the bytes that feed enabled targets
    for (genvar k = 0; k < PayloadBytes; k++) begin : g_payload
        always_ff @(posedge i_clk) begin
            if (i_step && pos == POS_PAYLOAD + 4'(k)) begin
                r_payload[k] <= i_rx_byte;
            end
        end
    end

    // status checks in priority order
    always_comb begin
        if (!r_start_ok) begin
            status = STATUS_BAD_START;
        end else if (!r_length_ok) begin
            status = STATUS_BAD_LEN;
        end else if (rx_crc != r_crc) begin
            status = STATUS_BAD_CRC;
        end else begin
            status = STATUS_OK;
        end
    end

    // little-endian targets, zero on error or when disabled
    for (genvar j = 0; j < MAX_VALUES; j++) begin : g_target
        if (j < VALUE_COUNT) begin : g_on
            assign targets[j] = (status == STATUS_OK) ?
                                {r_payload[2*j+1], r_payload[2*j]} : 16'sd0;
        end else begin : g_off
            assign targets[j] = 16'sd0;
        end
    end

    assign o_result.status   = status;
    assign o_result.target_0 = targets[0];
    assign o_result.target_1 = targets[1];
    assign o_result.target_2 = targets[2];
    assign o_result.target_3 = targets[3];
    assign o_result.target_4 = targets[4];
    assign o_result.target_5 = targets[5];

endmodule

// ----- rtl/core/crc16_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Groups received bytes into fixed 16-byte frames and reports one checked
// result with six signed targets per frame.
// ----------------------------------------------------------------------------
// Takes one byte per clock on the input channel. A byte with buffer_start
// set becomes frame position 0. Bytes 0..13 run through CRC16-Modbus
// (init FFFF, reflected poly A001); byte 0 is checked against start_byte,
// byte 1 against length_byte, bytes 14..15 hold the little-endian CRC.
// The byte at position 15 produces one transfer on the output channel:
// status (0 ok, 1 bad start, 2 bad length, 3 CRC mismatch) and six
// little-endian targets in hundredths, all zero unless status is ok;
// targets at or beyond VALUE_COUNT are always zero. Each byte passes
// through the input register into the parser; the result of the closing
// byte is loaded into the result register as that byte leaves the input
// register, once the output register is free. The CRC byte update is a
// shallow XOR network, so the block sustains one byte per cycle whenever
// the output register is free; a closing byte waits in the input register
// while an earlier result is still held. Configuration is to be written
// only while no byte is in flight.
// ----------------------------------------------------------------------------
module crc16_frame_receiver #(
    parameter int VALUE_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_buffer_start,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_frame_status,
    output logic signed [15:0] o_target_0,
    output logic signed [15:0] o_target_1,
    output logic signed [15:0] o_target_2,
    output logic signed [15:0] o_target_3,
    output logic signed [15:0] o_target_4,
    output logic signed [15:0] o_target_5
);
    import crcfr_pkg::*;

    logic [7:0] r_start_val;
    logic [7:0] r_length_val;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    logic       r_out_valid;
    t_result    r_out;

    logic       last;
    t_result    result;
    logic       out_free;
    logic       advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_val  <= START_RESET;
            r_length_val <= LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START:  r_start_val  <= i_cfg_data;
                REG_LENGTH: r_length_val <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake: stage advances unless a result is blocked
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!last || out_free);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_buffer_start;
        end
    end

    // frame state and result logic
    crcfr_parser #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_rx_byte      (r_in_byte),
        .i_buffer_start (r_in_start),
        .i_start_byte   (r_start_val),
        .i_length_byte  (r_length_val),
        .o_last         (last),
        .o_result       (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && last) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_out.status;
    assign o_target_0     = r_out.target_0;
    assign o_target_1     = r_out.target_1;
    assign o_target_2     = r_out.target_2;
    assign o_target_3     = r_out.target_3;
    assign o_target_4     = r_out.target_4;
    assign o_target_5     = r_out.target_5;

endmodule

// ----- test/crc16_frame_receiver_tb.sv -----
// ----------------------------------------------------------------------------
// crc16_frame_receiver_tb
// Self-checking bench for the fixed 16-byte CRC16-Modbus frame receiver.
// ----------------------------------------------------------------------------
// A directed frame table runs first at the reset register values. It covers
// all-zero and all-one payloads, the most negative and most positive
// targets, every status code, start and length errors together,
// realignment mid-frame and at the last byte, and a frame that follows
// another with no start flag. Random frames follow under several register
// settings, the extremes among them. Most are well-formed frames with
// random content; the rest carry bad start, length or CRC bytes, are cut
// short or are plain noise. Every accepted byte goes through a local
// frame parser; its results, or typed table values, are compared field by
// field with the output transfers. Both channels idle at random, and once
// the result side holds off long enough for the byte input to stall.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import crcfr_pkg::*;

    localparam int VALUE_COUNT = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [1:0]       status;
        logic [5:0][15:0] tgt;
    } frame_result_t;

    typedef enum logic [2:0] {
        FK_GOOD,
        FK_BAD_START,
        FK_BAD_LEN,
        FK_BAD_CRC,
        FK_BAD_BOTH,
        FK_CUT,
        FK_NOISE
    } frame_kind_e;

    // one directed frame; status and target are used only when typed is set
    typedef struct packed {
        frame_kind_e kind;
        logic        flag;
        logic        rnd;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [3:0]  cut;
        logic        typed;
        logic [1:0]  status;
        logic [15:0] tgt;
    } frame_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        i_buffer_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_frame_status;
    logic signed [15:0] o_target_0;
    logic signed [15:0] o_target_1;
    logic signed [15:0] o_target_2;
    logic signed [15:0] o_target_3;
    logic signed [15:0] o_target_4;
    logic signed [15:0] o_target_5;

    // register copies shared by the frame builder and the parser
    logic [7:0] cfg_start_byte;
    logic [7:0] cfg_length_byte;

    // local frame parser state
    logic [3:0]  pm_pos;
    logic [15:0] pm_crc;
    logic [7:0]  pm_payload [12];
    logic        pm_start_ok;
    logic        pm_len_ok;
    logic [7:0]  pm_crc_low;

    frame_result_t expected_frames [$];
    frame_row_t    directed_rows [0:11];
    int            error_count;
    int            sent_bytes;
    bit            tx_gappy;
    bit            rx_hold_req;

    crc16_frame_receiver #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_buffer_start (i_buffer_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_status (o_frame_status),
        .o_target_0     (o_target_0),
        .o_target_1     (o_target_1),
        .o_target_2     (o_target_2),
        .o_target_3     (o_target_3),
        .o_target_4     (o_target_4),
        .o_target_5     (o_target_5)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // reflected crc16, one data bit per step, lsb first
    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc_in,
                                                      input logic [7:0]  data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ data[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    // advance the frame parser by one byte; returns 1 when a frame closes
    function automatic bit parse_rx_byte(input logic [7:0] b, input logic flag,
                                         output frame_result_t res);
        logic [3:0]  p;
        logic [15:0] rx_crc;
        res = '0;
        if (flag) begin
            pm_pos = POS_START;
        end
        p = pm_pos;
        if (p == POS_START) begin
            pm_crc      = crc16_modbus_byte(CRC_INIT, b);
            pm_start_ok = (b == cfg_start_byte);
        end else if (p == POS_LENGTH) begin
            pm_crc    = crc16_modbus_byte(pm_crc, b);
            pm_len_ok = (b == cfg_length_byte);
        end else if (p < POS_CRC_LOW) begin
            pm_crc = crc16_modbus_byte(pm_crc, b);
            pm_payload[p - POS_PAYLOAD] = b;
        end else if (p == POS_CRC_LOW) begin
            pm_crc_low = b;
        end
        if (p != POS_LAST) begin
            pm_pos = p + 4'd1;
            return 1'b0;
        end
        rx_crc = {b, pm_crc_low};
        if (!pm_start_ok) begin
            res.status = STATUS_BAD_START;
        end else if (!pm_len_ok) begin
            res.status = STATUS_BAD_LEN;
        end else if (rx_crc != pm_crc) begin
            res.status = STATUS_BAD_CRC;
        end else begin
            res.status = STATUS_OK;
            for (int k = 0; k < VALUE_COUNT; k++) begin
                res.tgt[k] = {pm_payload[2*k+1], pm_payload[2*k]};
            end
        end
        pm_pos = POS_START;
        pm_crc = CRC_INIT;
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit gappy);
        int r;
        r = $urandom_range(0, 99);
        if (!gappy || r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // compare one output transfer with the oldest expected frame
    task automatic check_result();
        frame_result_t got;
        frame_result_t want;
        got.status = o_frame_status;
        got.tgt[0] = o_target_0;
        got.tgt[1] = o_target_1;
        got.tgt[2] = o_target_2;
        got.tgt[3] = o_target_3;
        got.tgt[4] = o_target_4;
        got.tgt[5] = o_target_5;
        if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("result transfer with none expected, status %0d",
                                      got.status));
        end else begin
            want = expected_frames.pop_front();
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status got %0d exp %0d", got.status, want.status));
            end
            for (int k = 0; k < 6; k++) begin
                if (got.tgt[k] !== want.tgt[k]) begin
                    report_mismatch($sformatf("target_%0d got %h exp %h",
                                              k, got.tgt[k], want.tgt[k]));
                end
            end
        end
    endtask

    // one byte transfer; called in the step of a rising edge, returns in the
    // step of the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic flag,
                             input bit use_typed, input frame_result_t typed);
        frame_result_t res;
        int            gap;
        gap = pick_gap(tx_gappy);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_rx_byte      <= b;
        i_buffer_start <= flag;
        do @(posedge i_clk); while (!o_in_ready);
        if (parse_rx_byte(b, flag, res)) begin
            expected_frames.push_back(use_typed ? typed : res);
        end
        sent_bytes++;
        if (sent_bytes % 100 == 0) begin
            tx_gappy = ($urandom_range(0, 2) != 0);
        end
    endtask

    // build one frame of the given kind and send it, or a burst of noise
    task automatic send_frame(input frame_kind_e kind, input logic flag, input logic rnd,
                              input logic [7:0] lo, input logic [7:0] hi, input int cut,
                              input bit use_typed, input frame_result_t typed);
        logic [7:0]  fb [16];
        logic [15:0] crc;
        int          n;
        if (kind == FK_NOISE) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom), ($urandom_range(0, 7) == 0), 1'b0, '0);
            end
        end else begin
            fb[0] = cfg_start_byte;
            fb[1] = cfg_length_byte;
            if (kind == FK_BAD_START || kind == FK_BAD_BOTH) begin
                fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
            end
            if (kind == FK_BAD_LEN || kind == FK_BAD_BOTH) begin
                fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
            end
            for (int i = 2; i < 14; i++) begin
                fb[i] = rnd ? 8'($urandom) : ((i % 2 == 0) ? lo : hi);
            end
            crc = CRC_INIT;
            for (int i = 0; i < 14; i++) begin
                crc = crc16_modbus_byte(crc, fb[i]);
            end
            if (kind == FK_BAD_CRC) begin
                crc = crc ^ 16'($urandom_range(1, 65535));
            end
            fb[14] = crc[7:0];
            fb[15] = crc[15:8];
            n = (kind == FK_CUT) ? cut : 16;
            for (int i = 0; i < n; i++) begin
                send_byte(fb[i], (i == 0) ? flag : 1'b0, use_typed && (i == 15), typed);
            end
        end
    endtask

    // random frames; ends on a frame boundary so the parser sits at byte 0
    task automatic run_random(input int n_bytes);
        int          stop;
        int          r;
        logic        flag;
        logic        rnd;
        logic [7:0]  ext [4];
        ext  = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        stop = sent_bytes + n_bytes;
        while (sent_bytes < stop) begin
            r    = $urandom_range(0, 99);
            flag = ($urandom_range(0, 4) != 0);
            rnd  = ($urandom_range(0, 9) != 0);
            if (r < 70) begin
                send_frame(FK_GOOD, flag, rnd, ext[$urandom_range(0, 3)],
                           ext[$urandom_range(0, 3)], 0, 1'b0, '0);
            end else if (r < 76) begin
                send_frame(FK_BAD_START, flag, 1'b1, 8'h00, 8'h00, 0, 1'b0, '0);
            end else if (r < 82) begin
                send_frame(FK_BAD_LEN, flag, 1'b1, 8'h00, 8'h00, 0, 1'b0, '0);
            end else if (r < 88) begin
                send_frame(FK_BAD_CRC, flag, 1'b1, 8'h00, 8'h00, 0, 1'b0, '0);
            end else if (r < 91) begin
                send_frame(FK_BAD_BOTH, flag, 1'b1, 8'h00, 8'h00, 0, 1'b0, '0);
            end else if (r < 96) begin
                send_frame(FK_CUT, flag, 1'b1, 8'h00, 8'h00, $urandom_range(1, 15),
                           1'b0, '0);
            end else begin
                send_frame(FK_NOISE, 1'b0, 1'b1, 8'h00, 8'h00, 0, 1'b0, '0);
            end
        end
        send_frame(FK_GOOD, 1'b1, 1'b1, 8'h00, 8'h00, 0, 1'b0, '0);
    endtask

    // let every expected frame come out, then give the pipeline time to settle
    task automatic wait_drained();
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // new register setting while the block is idle
    task automatic apply_settings(input logic [7:0] start_val, input logic [7:0] len_val);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_START;
        i_cfg_data  <= start_val;
        @(posedge i_clk);
        i_cfg_index <= REG_LENGTH;
        i_cfg_data  <= len_val;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        cfg_start_byte  = start_val;
        cfg_length_byte = len_val;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int hold_left;
        int cycles;
        bit gappy;
        hold_left = 0;
        cycles    = 0;
        gappy     = 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                check_result();
            end
            cycles++;
            if (cycles % 128 == 0) begin
                gappy = ($urandom_range(0, 2) != 0);
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD;
            end else if ($urandom_range(0, 99) < 12) begin
                hold_left = pick_gap(gappy);
            end
            i_out_ready <= (hold_left == 0);
        end
    end

    // watchdog: too long with no transfer on either channel
    initial begin : watchdog
        int idle;
        idle = 0;
        wait (i_rst_n === 1'b1);
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // main sequence
    initial begin
        frame_result_t typed;
        frame_row_t    row;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_START;
        i_cfg_data     = 8'h00;
        i_in_valid     = 1'b0;
        i_rx_byte      = 8'h00;
        i_buffer_start = 1'b0;
        i_out_ready    = 1'b0;
        error_count    = 0;
        sent_bytes     = 0;
        tx_gappy       = 1'b1;
        rx_hold_req    = 1'b0;
        cfg_start_byte  = START_RESET;
        cfg_length_byte = LENGTH_RESET;
        pm_pos      = POS_START;
        pm_crc      = CRC_INIT;
        pm_start_ok = 1'b0;
        pm_len_ok   = 1'b0;
        pm_crc_low  = 8'h00;
        foreach (pm_payload[i]) pm_payload[i] = 8'h00;

        // kind, start flag, random payload, lo, hi, cut, typed, status, target
        directed_rows = '{
            '{FK_GOOD,      1'b1, 1'b0, 8'h00, 8'h00, 4'd0,  1'b1, STATUS_OK,        16'h0000},
            '{FK_GOOD,      1'b0, 1'b0, 8'hFF, 8'hFF, 4'd0,  1'b1, STATUS_OK,        16'hFFFF},
            '{FK_GOOD,      1'b1, 1'b0, 8'h00, 8'h80, 4'd0,  1'b1, STATUS_OK,        16'h8000},
            '{FK_GOOD,      1'b1, 1'b0, 8'hFF, 8'h7F, 4'd0,  1'b1, STATUS_OK,        16'h7FFF},
            '{FK_BAD_START, 1'b1, 1'b0, 8'h12, 8'h34, 4'd0,  1'b1, STATUS_BAD_START, 16'h0000},
            '{FK_BAD_LEN,   1'b1, 1'b0, 8'h56, 8'h78, 4'd0,  1'b1, STATUS_BAD_LEN,   16'h0000},
            '{FK_BAD_CRC,   1'b1, 1'b0, 8'h9A, 8'hBC, 4'd0,  1'b1, STATUS_BAD_CRC,   16'h0000},
            '{FK_BAD_BOTH,  1'b1, 1'b0, 8'hDE, 8'hF0, 4'd0,  1'b1, STATUS_BAD_START, 16'h0000},
            '{FK_CUT,       1'b1, 1'b1, 8'h00, 8'h00, 4'd7,  1'b0, STATUS_OK,        16'h0000},
            '{FK_GOOD,      1'b1, 1'b1, 8'h00, 8'h00, 4'd0,  1'b0, STATUS_OK,        16'h0000},
            '{FK_CUT,       1'b1, 1'b1, 8'h00, 8'h00, 4'd15, 1'b0, STATUS_OK,        16'h0000},
            '{FK_GOOD,      1'b1, 1'b1, 8'h00, 8'h00, 4'd0,  1'b0, STATUS_OK,        16'h0000}
        };

        // synchronous reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the reset register values
        foreach (directed_rows[i]) begin
            row          = directed_rows[i];
            typed        = '0;
            typed.status = row.status;
            if (row.status == STATUS_OK) begin
                for (int k = 0; k < VALUE_COUNT; k++) typed.tgt[k] = row.tgt;
            end
            send_frame(row.kind, row.flag, row.rnd, row.lo, row.hi, row.cut,
                       row.typed, typed);
        end

        // random frames, first phase with the long result hold-off
        rx_hold_req = 1'b1;
        run_random(450);
        apply_settings(8'h00, 8'h00);
        run_random(400);
        apply_settings(8'hFF, 8'hFF);
        run_random(400);
        apply_settings(8'($urandom), 8'($urandom));
        run_random(350);

        i_in_valid <= 1'b0;
        wait_drained();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
